[sv/tsm_pkg.sv]
`default_nettype none
package tsm_pkg;

    localparam int PROGRAMS     = 16;
    localparam int QUEUE_DEPTH  = 1024;
    localparam int COMMAND_RING = 4096;

    localparam int PW          = $clog2(PROGRAMS);
    localparam int QW          = $clog2(QUEUE_DEPTH);
    localparam int CW          = $clog2(COMMAND_RING);
    localparam int AW          = PW + QW;
    localparam int MEM_DEPTH   = PROGRAMS * (2 ** QW);
    localparam int REC_W       = 62;
    localparam int ENABLE_BITS = 16;
    localparam int SCAN_W      = 5;
    localparam int CFG_AW      = 3;
    localparam int CFG_DW      = 16;

    localparam logic [12:0] NULL_PID = 13'h1FFF;

    typedef enum logic [1:0] {
        ST_SERVED   = 2'd0,
        ST_NULL     = 2'd1,
        ST_ENQUEUED = 2'd2,
        ST_DROPPED  = 2'd3
    } t_status;

    typedef enum logic [CFG_AW-1:0] {
        CFG_PROGRAM_COUNT    = 3'd0,
        CFG_PROGRAM_ENABLE   = 3'd1,
        CFG_SLOTS_PER_WINDOW = 3'd2,
        CFG_CHANNEL_COUNT    = 3'd3,
        CFG_CHANNEL_INDEX    = 3'd4
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ,
        S_SCAN,
        S_DECIDE,
        S_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic enq;
        logic scan;
        logic decide;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

[sv/tsm_if.sv]
`default_nettype none
interface tsm_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [3:0]  program_req;
    logic [31:0] delivery_time;
    logic [12:0] out_pid;
    logic        has_pcr;
    logic [15:0] buffer_addr;
    logic [31:0] slot_time;

    modport source (output valid, req_type, program_req, delivery_time, out_pid, has_pcr,
                    buffer_addr, slot_time, input ready);
    modport sink   (input valid, req_type, program_req, delivery_time, out_pid, has_pcr,
                    buffer_addr, slot_time, output ready);
endinterface

interface tsm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  served_program;
    logic [12:0] sent_pid;
    logic        sent_pcr;
    logic [15:0] sent_addr;
    logic [11:0] command_index;

    modport source (output valid, status, served_program, sent_pid, sent_pcr, sent_addr,
                    command_index, input ready);
    modport sink   (input valid, status, served_program, sent_pid, sent_pcr, sent_addr,
                    command_index, output ready);
endinterface

interface tsm_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [tsm_pkg::CFG_AW-1:0] index;
    logic [tsm_pkg::CFG_DW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[sv/tsm_ram.sv]
`default_nettype none
module tsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[sv/tsm_ctrl.sv]
`default_nettype none
module tsm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_req_slot,
    output      logic          o_in_ready,
    input  wire tsm_pkg::t_sts i_sts,
    output      tsm_pkg::t_cmd o_cmd
);
    tsm_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tsm_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_req_slot ? tsm_pkg::S_SCAN : tsm_pkg::S_ENQ;
                end
            end
            tsm_pkg::S_ENQ:    n_state = tsm_pkg::S_RESP;
            tsm_pkg::S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = tsm_pkg::S_DECIDE;
                end
            end
            tsm_pkg::S_DECIDE: n_state = tsm_pkg::S_RESP;
            tsm_pkg::S_RESP: begin
                if (i_sts.out_free) begin
                    n_state = tsm_pkg::S_IDLE;
                end
            end
            default:           n_state = tsm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            tsm_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            tsm_pkg::S_ENQ:    o_cmd.enq    = 1'b1;
            tsm_pkg::S_SCAN:   o_cmd.scan   = 1'b1;
            tsm_pkg::S_DECIDE: o_cmd.decide = 1'b1;
            tsm_pkg::S_RESP:   o_cmd.emit   = i_sts.out_free;
            default: begin
            end
        endcase
    end
endmodule
`default_nettype wire

[sv/tsm_dp.sv]
`default_nettype none
module tsm_dp (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire tsm_pkg::t_cmd              i_cmd,
    output      tsm_pkg::t_sts              o_sts,
    input  wire logic                       i_cfg_we,
    input  wire logic [tsm_pkg::CFG_AW-1:0] i_cfg_index,
    input  wire logic [tsm_pkg::CFG_DW-1:0] i_cfg_data,
    input  wire logic [3:0]                 i_program_req,
    input  wire logic [31:0]                i_delivery_time,
    input  wire logic [12:0]                i_out_pid,
    input  wire logic                       i_has_pcr,
    input  wire logic [15:0]                i_buffer_addr,
    input  wire logic [31:0]                i_slot_time,
    input  wire logic                       i_out_ready,
    output      logic                       o_out_valid,
    output      logic [1:0]                 o_status,
    output      logic [3:0]                 o_served_program,
    output      logic [12:0]                o_sent_pid,
    output      logic                       o_sent_pcr,
    output      logic [15:0]                o_sent_addr,
    output      logic [11:0]                o_command_index
);
    localparam int PW = tsm_pkg::PW;
    localparam int QW = tsm_pkg::QW;
    localparam int CW = tsm_pkg::CW;

    logic [4:0]  r_prog_count;
    logic [15:0] r_prog_en;
    logic [7:0]  r_spw;
    logic [4:0]  r_ch_count;
    logic [4:0]  r_ch_index;

    logic [QW-1:0] r_rd [tsm_pkg::PROGRAMS];
    logic [QW-1:0] r_wr [tsm_pkg::PROGRAMS];
    logic [7:0]    r_slot_cnt;
    logic [CW-1:0] r_cmd_base;

    logic [3:0]                r_req_prog;
    logic [tsm_pkg::REC_W-1:0] r_req_rec;
    logic [31:0]               r_now;

    logic [tsm_pkg::SCAN_W-1:0] r_scan;
    logic                       r_cmp_vld;
    logic [PW-1:0]              r_cmp_idx;
    logic                       r_found;
    logic [PW-1:0]              r_best;
    logic [tsm_pkg::REC_W-1:0]  r_best_rec;

    logic [1:0]  r_res_status;
    logic [3:0]  r_res_prog;
    logic [12:0] r_res_pid;
    logic        r_res_pcr;
    logic [15:0] r_res_addr;
    logic [11:0] r_res_cmd;

    logic [tsm_pkg::SCAN_W-1:0] w_limit;
    logic                       w_scan_done;
    logic [PW-1:0]              w_idx;
    logic [QW-1:0]              w_rdp;
    logic [QW-1:0]              w_wrp;
    logic [QW-1:0]              w_wr_nxt;
    logic [QW-1:0]              w_rd_nxt;
    logic                       w_full;
    logic                       w_elig;
    logic                       w_we;
    logic [tsm_pkg::REC_W-1:0]  w_rdata;
    logic [31:0]                w_diff;
    logic                       w_null;
    logic [31:0]                w_off;
    logic [31:0]                w_cmd_sum;
    logic                       w_win_end;

    always_comb begin
        w_limit = r_prog_count;
        if (32'(r_prog_count) > tsm_pkg::PROGRAMS) begin
            w_limit = tsm_pkg::SCAN_W'(tsm_pkg::PROGRAMS);
        end
        if (32'(w_limit) > tsm_pkg::ENABLE_BITS) begin
            w_limit = tsm_pkg::SCAN_W'(tsm_pkg::ENABLE_BITS);
        end
    end

    assign w_scan_done = (r_scan >= w_limit);

    always_comb begin
        priority if (i_cmd.enq) begin
            w_idx = PW'(r_req_prog);
        end else if (i_cmd.scan) begin
            w_idx = PW'(r_scan);
        end else begin
            w_idx = r_best;
        end
    end

    assign w_rdp    = r_rd[w_idx];
    assign w_wrp    = r_wr[w_idx];
    assign w_wr_nxt = (32'(w_wrp) == tsm_pkg::QUEUE_DEPTH - 1) ? '0 : w_wrp + 1'b1;
    assign w_rd_nxt = (32'(w_rdp) == tsm_pkg::QUEUE_DEPTH - 1) ? '0 : w_rdp + 1'b1;
    assign w_full   = (32'(r_req_prog) >= tsm_pkg::PROGRAMS) || (w_wr_nxt == w_rdp);
    assign w_elig   = i_cmd.scan && !w_scan_done && r_prog_en[r_scan[3:0]] && (w_rdp != w_wrp);
    assign w_we     = i_cmd.enq && !w_full;

    tsm_ram #(
        .WIDTH(tsm_pkg::REC_W),
        .DEPTH(tsm_pkg::MEM_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr({w_idx, w_wrp}),
        .i_wdata(r_req_rec),
        .i_raddr({w_idx, w_rdp}),
        .o_rdata(w_rdata)
    );

    assign w_diff    = r_best_rec[31:0] - r_now;
    assign w_null    = !r_found || ((w_diff != 32'd0) && !w_diff[31]);
    assign w_off     = 32'(r_slot_cnt) * 32'(r_ch_count) + 32'(r_ch_index);
    assign w_cmd_sum = 32'(r_cmd_base) + 32'(w_off[CW-1:0]);
    assign w_win_end = (9'(r_slot_cnt) + 9'd1) >= 9'(r_spw);

    assign o_sts.scan_done = w_scan_done;
    assign o_sts.out_free  = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_count <= '0;
            r_prog_en    <= '0;
            r_spw        <= 8'd1;
            r_ch_count   <= 5'd1;
            r_ch_index   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tsm_pkg::CFG_PROGRAM_COUNT:    r_prog_count <= i_cfg_data[4:0];
                tsm_pkg::CFG_PROGRAM_ENABLE:   r_prog_en    <= i_cfg_data;
                tsm_pkg::CFG_SLOTS_PER_WINDOW: r_spw        <= i_cfg_data[7:0];
                tsm_pkg::CFG_CHANNEL_COUNT:    r_ch_count   <= i_cfg_data[4:0];
                tsm_pkg::CFG_CHANNEL_INDEX:    r_ch_index   <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < tsm_pkg::PROGRAMS; p++) begin
                r_rd[p] <= '0;
                r_wr[p] <= '0;
            end
            r_slot_cnt <= '0;
            r_cmd_base <= '0;
        end else begin
            if (w_we) begin
                r_wr[w_idx] <= w_wr_nxt;
            end
            if (i_cmd.decide) begin
                if (!w_null) begin
                    r_rd[w_idx] <= w_rd_nxt;
                end
                if (w_win_end) begin
                    r_slot_cnt <= '0;
                    r_cmd_base <= CW'(32'(r_cmd_base) + 32'(r_ch_count) * 32'(r_spw));
                end else begin
                    r_slot_cnt <= r_slot_cnt + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_prog <= i_program_req;
            r_req_rec  <= {i_buffer_addr, i_has_pcr, i_out_pid, i_delivery_time};
            r_now      <= i_slot_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan    <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_cmp_vld <= w_elig;
            if (i_cmd.load) begin
                r_scan  <= '0;
                r_found <= 1'b0;
            end else begin
                if (i_cmd.scan && !w_scan_done) begin
                    r_scan <= r_scan + 1'b1;
                end
                if (r_cmp_vld && (!r_found || (w_rdata[31:0] < r_best_rec[31:0]))) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_elig) begin
            r_cmp_idx <= w_idx;
        end
        if (r_cmp_vld && (!r_found || (w_rdata[31:0] < r_best_rec[31:0]))) begin
            r_best     <= r_cmp_idx;
            r_best_rec <= w_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.enq) begin
            r_res_status <= w_full ? tsm_pkg::ST_DROPPED : tsm_pkg::ST_ENQUEUED;
            r_res_prog   <= '0;
            r_res_pid    <= '0;
            r_res_pcr    <= 1'b0;
            r_res_addr   <= '0;
            r_res_cmd    <= '0;
        end else if (i_cmd.decide) begin
            r_res_cmd <= 12'(w_cmd_sum[CW-1:0]);
            if (w_null) begin
                r_res_status <= tsm_pkg::ST_NULL;
                r_res_prog   <= '0;
                r_res_pid    <= tsm_pkg::NULL_PID;
                r_res_pcr    <= 1'b0;
                r_res_addr   <= '0;
            end else begin
                r_res_status <= tsm_pkg::ST_SERVED;
                r_res_prog   <= 4'(r_best);
                r_res_pid    <= r_best_rec[44:32];
                r_res_pcr    <= r_best_rec[45];
                r_res_addr   <= r_best_rec[61:46];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_status         <= r_res_status;
            o_served_program <= r_res_prog;
            o_sent_pid       <= r_res_pid;
            o_sent_pcr       <= r_res_pcr;
            o_sent_addr      <= r_res_addr;
            o_command_index  <= r_res_cmd;
        end
    end

`ifndef SYNTHESIS
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.load, i_cmd.enq, i_cmd.scan, i_cmd.decide, i_cmd.emit}))
        else $error("more than one datapath command at once");

    a_enq_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.enq && !w_full) |=> (r_res_status == tsm_pkg::ST_ENQUEUED))
        else $error("accepted record not reported as enqueued");

    a_serve_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.decide && !w_null) |=> (r_res_status == tsm_pkg::ST_SERVED))
        else $error("due head not reported as served");

    a_no_cmp_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.scan |=> !r_cmp_vld)
        else $error("head compare outside a scan");
`endif
endmodule
`default_nettype wire

[sv/ts_mux_earliest_deadline_slot_unit.sv]
`default_nettype none
// Channel  Dir  Handshake     Payload
// i_in     in   valid/ready   req_type, program_req, delivery_time, out_pid, has_pcr,
//                             buffer_addr, slot_time
// o_out    out  valid/ready   status, served_program, sent_pid, sent_pcr, sent_addr,
//                             command_index
// i_cfg    in   valid/ready   index, data (ready always high)
//
// Enqueue request: registered on accept, then stored in S_ENQ (one store write port).
// Slot request: scans the first min(program_count, 16) queues; one queue head is read
// per cycle from the shared record store.
// Reset is synchronous; queues come up empty, the record store itself is not cleared.
// A result waits in the output register; while the sink stalls, one more request is
// taken and its result is held until the register frees.
module ts_mux_earliest_deadline_slot_unit (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    tsm_in_if.sink    i_in,
    tsm_out_if.source o_out,
    tsm_cfg_if.sink   i_cfg
);
    tsm_pkg::t_cmd w_cmd;
    tsm_pkg::t_sts w_sts;

    assign i_cfg.ready = 1'b1;

    tsm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in.valid),
        .i_req_slot(i_in.req_type),
        .o_in_ready(i_in.ready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    tsm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .i_program_req   (i_in.program_req),
        .i_delivery_time (i_in.delivery_time),
        .i_out_pid       (i_in.out_pid),
        .i_has_pcr       (i_in.has_pcr),
        .i_buffer_addr   (i_in.buffer_addr),
        .i_slot_time     (i_in.slot_time),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_status        (o_out.status),
        .o_served_program(o_out.served_program),
        .o_sent_pid      (o_out.sent_pid),
        .o_sent_pcr      (o_out.sent_pcr),
        .o_sent_addr     (o_out.sent_addr),
        .o_command_index (o_out.command_index)
    );
endmodule
`default_nettype wire
